FILE: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL modules.
// Each macro expects clk_i to be visible where it is used; CLNS_ASSERT also rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside of reset.
`define CLNS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// Property checked on every rising edge, reset included.
`define CLNS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");

`endif

FILE: hw/rtl/clns_pkg.sv
package clns_pkg;

  // Request type codes.
  localparam logic [2:0] REQ_CMD     = 3'd0;
  localparam logic [2:0] REQ_CHAR    = 3'd1;
  localparam logic [2:0] REQ_GOTO    = 3'd2;
  localparam logic [2:0] REQ_CHAR_AT = 3'd3;
  localparam logic [2:0] REQ_INIT    = 3'd4;

  // Segment group selected by the controller.
  localparam logic [1:0] KIND_PRE  = 2'd0;
  localparam logic [1:0] KIND_CMD  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  // Last segment index of each group.
  localparam logic [2:0] PRE_LAST_SEG  = 3'd3;
  localparam logic [2:0] CMD_LAST_SEG  = 3'd4;
  localparam logic [2:0] DATA_LAST_SEG = 3'd5;

  // Number of setup commands in the power-up sequence, minus one.
  localparam logic [2:0] INIT_LAST_IDX = 3'd4;

  // Display row base addresses.
  localparam logic [1:0] ROW_FIRST   = 2'd1;
  localparam logic [1:0] ROW_SECOND  = 2'd2;
  localparam logic [7:0] ROW1_BASE   = 8'h80;
  localparam logic [7:0] ROW2_BASE   = 8'hC0;

  // Power-up setup commands.
  localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
  localparam logic [7:0] CMD_DISP_OFF  = 8'h08;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_ENTRY     = 8'h06;
  localparam logic [7:0] CMD_DISP_ON   = 8'h0C;

  // Unstrobed wake-up nibbles of the power-up sequence.
  localparam logic [3:0] WAKE_NIB_A = 4'h3;
  localparam logic [3:0] WAKE_NIB_B = 4'h2;
  localparam logic [3:0] WAKE_NIB_C = 4'h0;

  // Hold times in milliseconds.
  localparam logic [4:0] HOLD_POWER = 5'd20;
  localparam logic [4:0] HOLD_WAKE  = 5'd5;
  localparam logic [4:0] HOLD_ZERO  = 5'd0;
  localparam logic [4:0] HOLD_PULSE = 5'd2;
  localparam logic [4:0] HOLD_HI    = 5'd6;
  localparam logic [4:0] HOLD_LO    = 5'd5;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic       load;      // capture the request fields
    logic       emit;      // produce one segment this cycle
    logic [1:0] kind;      // segment group
    logic [2:0] seg;       // segment index within the group
    logic       use_init;  // command byte comes from the setup table
    logic       use_goto;  // command byte is the goto address
    logic [2:0] init_idx;  // setup table index
    logic       last;      // final segment of the request
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic can_emit;  // output stage can take a segment
    logic row_ok;    // requested row addresses the display
  } dp_sts_t;

  // Setup command table of the power-up sequence.
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = CMD_FUNC_SET;
      3'd1:    b = CMD_DISP_OFF;
      3'd2:    b = CMD_CLEAR;
      3'd3:    b = CMD_ENTRY;
      default: b = CMD_DISP_ON;
    endcase
    return b;
  endfunction

endpackage

FILE: hw/rtl/clns_req_if.sv
interface clns_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] byte_value;
  logic [1:0] row;
  logic [7:0] column;

  modport source (output valid, output req_type, output byte_value, output row,
                  output column, input ready);
  modport sink (input valid, input req_type, input byte_value, input row,
                input column, output ready);
endinterface

FILE: hw/rtl/clns_seg_if.sv
interface clns_seg_if;
  logic       valid;
  logic       ready;
  logic       rs_level;
  logic       en_level;
  logic [3:0] data_nibble;
  logic [4:0] hold_ms;
  logic       last;

  modport source (output valid, output rs_level, output en_level,
                  output data_nibble, output hold_ms, output last, input ready);
  modport sink (input valid, input rs_level, input en_level, input data_nibble,
                input hold_ms, input last, output ready);
endinterface

FILE: hw/rtl/clns_ctrl.sv
`include "assert_macros.svh"

module clns_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  input  logic [2:0]        req_type_i,
  output logic              req_ready_o,
  input  clns_pkg::dp_sts_t sts_i,
  output clns_pkg::dp_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PRE  = 2'd1;
  localparam logic [1:0] ST_CMD  = 2'd2;
  localparam logic [1:0] ST_DATA = 2'd3;

  logic [1:0] state_q, state_d;
  logic [2:0] seg_q, seg_d;
  logic [2:0] init_idx_q, init_idx_d;
  logic       init_mode_q, init_mode_d;
  logic       goto_mode_q, goto_mode_d;
  logic       data_after_q, data_after_d;
  logic       fire;
  logic       emit;
  logic       more_init;

  assign req_ready_o = (state_q == ST_IDLE);
  assign fire        = req_valid_i && req_ready_o;
  assign emit        = (state_q != ST_IDLE) && sts_i.can_emit;
  assign more_init   = init_mode_q && (init_idx_q != clns_pkg::INIT_LAST_IDX);

  // Command to the datapath.
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = fire;
    cmd_o.emit     = emit;
    cmd_o.seg      = seg_q;
    cmd_o.use_init = init_mode_q;
    cmd_o.use_goto = goto_mode_q;
    cmd_o.init_idx = init_idx_q;
    unique case (state_q)
      ST_PRE:  cmd_o.kind = clns_pkg::KIND_PRE;
      ST_CMD:  cmd_o.kind = clns_pkg::KIND_CMD;
      default: cmd_o.kind = clns_pkg::KIND_DATA;
    endcase
    cmd_o.last = ((state_q == ST_CMD) && (seg_q == clns_pkg::CMD_LAST_SEG) &&
                  !more_init && !data_after_q) ||
                 ((state_q == ST_DATA) && (seg_q == clns_pkg::DATA_LAST_SEG));
  end

  // Sequencing of requests into segment groups.
  always_comb begin
    state_d      = state_q;
    seg_d        = seg_q;
    init_idx_d   = init_idx_q;
    init_mode_d  = init_mode_q;
    goto_mode_d  = goto_mode_q;
    data_after_d = data_after_q;
    unique case (state_q)
      ST_IDLE: begin
        if (fire) begin
          seg_d        = '0;
          init_idx_d   = '0;
          init_mode_d  = 1'b0;
          goto_mode_d  = 1'b0;
          data_after_d = 1'b0;
          unique case (req_type_i)
            clns_pkg::REQ_CMD:  state_d = ST_CMD;
            clns_pkg::REQ_CHAR: state_d = ST_DATA;
            clns_pkg::REQ_GOTO: begin
              goto_mode_d = 1'b1;
              if (sts_i.row_ok) state_d = ST_CMD;
            end
            clns_pkg::REQ_CHAR_AT: begin
              goto_mode_d  = 1'b1;
              data_after_d = 1'b1;
              state_d      = sts_i.row_ok ? ST_CMD : ST_DATA;
            end
            clns_pkg::REQ_INIT: begin
              init_mode_d = 1'b1;
              state_d     = ST_PRE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_PRE: begin
        if (emit) begin
          seg_d = seg_q + 3'd1;
          if (seg_q == clns_pkg::PRE_LAST_SEG) begin
            seg_d   = '0;
            state_d = ST_CMD;
          end
        end
      end
      ST_CMD: begin
        if (emit) begin
          seg_d = seg_q + 3'd1;
          if (seg_q == clns_pkg::CMD_LAST_SEG) begin
            seg_d = '0;
            if (more_init) begin
              init_idx_d = init_idx_q + 3'd1;
            end else if (data_after_q) begin
              state_d = ST_DATA;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        if (emit) begin
          seg_d = seg_q + 3'd1;
          if (seg_q == clns_pkg::DATA_LAST_SEG) begin
            seg_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seg_q        <= '0;
      init_idx_q   <= '0;
      init_mode_q  <= 1'b0;
      goto_mode_q  <= 1'b0;
      data_after_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      seg_q        <= seg_d;
      init_idx_q   <= init_idx_d;
      init_mode_q  <= init_mode_d;
      goto_mode_q  <= goto_mode_d;
      data_after_q <= data_after_d;
    end
  end

  `CLNS_ASSERT(a_last_ends_request, emit && cmd_o.last |=> state_q == ST_IDLE)
  `CLNS_ASSERT_ALWAYS(a_init_idx_range, init_idx_q <= clns_pkg::INIT_LAST_IDX)
  `CLNS_ASSERT(a_cmd_seg_range, state_q == ST_CMD |-> seg_q <= clns_pkg::CMD_LAST_SEG)
  `CLNS_ASSERT(a_pre_only_init, state_q == ST_PRE |-> init_mode_q)

endmodule

FILE: hw/rtl/clns_datapath.sv
`include "assert_macros.svh"

module clns_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  clns_pkg::dp_cmd_t cmd_i,
  output clns_pkg::dp_sts_t sts_o,
  input  logic [7:0]        byte_value_i,
  input  logic [1:0]        row_i,
  input  logic [7:0]        column_i,
  input  logic              seg_ready_i,
  output logic              seg_valid_o,
  output logic              rs_level_o,
  output logic              en_level_o,
  output logic [3:0]        data_nibble_o,
  output logic [4:0]        hold_ms_o,
  output logic              last_o
);

  logic [7:0] req_byte_q;
  logic [7:0] goto_byte_q, goto_byte_d;
  logic [7:0] row_base;
  logic [3:0] drv_nib_q;
  logic       drv_rs_q, drv_en_q;
  logic [7:0] cmd_byte;
  logic [3:0] hi, lo;
  logic       rs, en;
  logic [3:0] nib;
  logic [4:0] hold;
  logic       out_valid_q;
  logic       out_rs_q, out_en_q, out_last_q;
  logic [3:0] out_nib_q;
  logic [4:0] out_hold_q;

  // Row decode and goto address, wrapping at 256.
  assign sts_o.row_ok = (row_i == clns_pkg::ROW_FIRST) || (row_i == clns_pkg::ROW_SECOND);
  assign row_base     = (row_i == clns_pkg::ROW_FIRST) ? clns_pkg::ROW1_BASE
                                                       : clns_pkg::ROW2_BASE;
  assign goto_byte_d  = row_base + column_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_byte_q  <= byte_value_i;
      goto_byte_q <= goto_byte_d;
    end
  end

  // Byte being sent and its nibbles.
  always_comb begin
    if (cmd_i.kind == clns_pkg::KIND_DATA) begin
      cmd_byte = req_byte_q;
    end else if (cmd_i.use_init) begin
      cmd_byte = clns_pkg::init_cmd(cmd_i.init_idx);
    end else if (cmd_i.use_goto) begin
      cmd_byte = goto_byte_q;
    end else begin
      cmd_byte = req_byte_q;
    end
  end
  assign hi = cmd_byte[7:4];
  assign lo = cmd_byte[3:0];

  // Pin levels and hold time of the current segment.
  always_comb begin
    rs   = 1'b0;
    en   = 1'b0;
    nib  = '0;
    hold = clns_pkg::HOLD_PULSE;
    unique case (cmd_i.kind)
      clns_pkg::KIND_PRE: begin
        en = drv_en_q;
        unique case (cmd_i.seg)
          3'd0: begin
            rs   = drv_rs_q;
            nib  = drv_nib_q;
            hold = clns_pkg::HOLD_POWER;
          end
          3'd1: begin
            nib  = clns_pkg::WAKE_NIB_A;
            hold = clns_pkg::HOLD_WAKE;
          end
          3'd2: begin
            nib  = clns_pkg::WAKE_NIB_B;
            hold = clns_pkg::HOLD_WAKE;
          end
          default: begin
            nib  = clns_pkg::WAKE_NIB_C;
            hold = clns_pkg::HOLD_ZERO;
          end
        endcase
      end
      clns_pkg::KIND_CMD: begin
        unique case (cmd_i.seg)
          3'd0: nib = drv_nib_q;
          3'd1: begin
            en  = 1'b1;
            nib = hi;
          end
          3'd2: begin
            nib  = hi;
            hold = clns_pkg::HOLD_HI;
          end
          3'd3: begin
            en  = 1'b1;
            nib = lo;
          end
          default: begin
            nib  = lo;
            hold = clns_pkg::HOLD_LO;
          end
        endcase
      end
      clns_pkg::KIND_DATA: begin
        rs = 1'b1;
        unique case (cmd_i.seg)
          3'd0: nib = drv_nib_q;
          3'd1: begin
            en  = 1'b1;
            nib = hi;
          end
          3'd2: nib = hi;
          3'd4: begin
            en  = 1'b1;
            nib = lo;
          end
          default: nib = lo;
        endcase
      end
      default: begin
        rs   = 1'b0;
        en   = 1'b0;
        nib  = '0;
        hold = clns_pkg::HOLD_ZERO;
      end
    endcase
  end

  // Pin levels currently driven.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drv_nib_q <= '0;
      drv_rs_q  <= 1'b0;
      drv_en_q  <= 1'b0;
    end else if (cmd_i.emit) begin
      drv_nib_q <= nib;
      drv_rs_q  <= rs;
      drv_en_q  <= en;
    end
  end

  // Output register: a new segment enters when the slot is empty or being taken.
  assign sts_o.can_emit = !out_valid_q || seg_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (seg_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_rs_q   <= rs;
      out_en_q   <= en;
      out_nib_q  <= nib;
      out_hold_q <= hold;
      out_last_q <= cmd_i.last;
    end
  end

  assign seg_valid_o   = out_valid_q;
  assign rs_level_o    = out_rs_q;
  assign en_level_o    = out_en_q;
  assign data_nibble_o = out_nib_q;
  assign hold_ms_o     = out_hold_q;
  assign last_o        = out_last_q;

  `CLNS_ASSERT(a_emit_has_room, cmd_i.emit |-> sts_o.can_emit)
  `CLNS_ASSERT(a_emit_tracks_pins, cmd_i.emit |=> out_valid_q && drv_nib_q == out_nib_q)
  `CLNS_ASSERT(a_out_held, out_valid_q && !seg_ready_i |=> out_valid_q && $stable(out_nib_q))

endmodule

FILE: hw/rtl/char_lcd_nibble_sequencer.sv
// Character LCD sequencer for a 4-bit parallel display bus.
// The request channel takes one request per transfer: a command byte, a
// character at the cursor, a goto to row/column, a character at row/column
// or the power-up init. Each request expands into a run of pin segments on
// the segment channel (register select, enable, data nibble, hold time in
// ms), high nibble first, with last set on the final segment.
// A command gives 5 segments, a character 6, a placed character 11, init 29.
// A goto to a row other than 1 or 2 gives none; unknown types give none.
// The sequencer emits one segment per cycle from a single output register
// while the receiver does not stall; the next request is taken once the
// last segment has entered the output register.
// When the receiver stalls, the output register holds its segment and the
// sequencer waits; no segment is dropped or repeated.
// Reset clears the driven pin levels to zero and empties the output stage.
module char_lcd_nibble_sequencer (
  input logic       clk_i,
  input logic       rst_ni,
  clns_req_if.sink  req_i,
  clns_seg_if.source seg_o
);

  clns_pkg::dp_cmd_t cmd;
  clns_pkg::dp_sts_t sts;

  // Sequencer control.
  clns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Segment generation and output register.
  clns_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .byte_value_i  (req_i.byte_value),
    .row_i         (req_i.row),
    .column_i      (req_i.column),
    .seg_ready_i   (seg_o.ready),
    .seg_valid_o   (seg_o.valid),
    .rs_level_o    (seg_o.rs_level),
    .en_level_o    (seg_o.en_level),
    .data_nibble_o (seg_o.data_nibble),
    .hold_ms_o     (seg_o.hold_ms),
    .last_o        (seg_o.last)
  );

endmodule

FILE: tb/lcd_segment_checker.sv
// Watches the request and segment channels of the LCD sequencer, expands
// each accepted request into the pin segments it must produce and compares
// every segment transfer against the oldest one still outstanding.
module lcd_segment_checker (
  input  logic clk_i,
  input  logic rst_ni,
  clns_req_if  req_mon,
  clns_seg_if  seg_mon,
  output int   fail_count_o,
  output int   pending_o
);

  // One pin segment as it appears on the segment channel.
  typedef struct packed {
    logic       rs;
    logic       en;
    logic [3:0] nibble;
    logic [4:0] hold_ms;
    logic       last;
  } pin_seg_t;

  // Hold times in milliseconds.
  localparam logic [4:0] MS_PULSE  = 5'd2;
  localparam logic [4:0] MS_CMD_HI = 5'd6;
  localparam logic [4:0] MS_CMD_LO = 5'd5;
  localparam logic [4:0] MS_POWER  = 5'd20;
  localparam logic [4:0] MS_WAKE   = 5'd5;
  localparam logic [4:0] MS_NONE   = 5'd0;

  // Display addresses and the power-up setup commands.
  localparam logic [7:0] ADDR_ROW1   = 8'h80;
  localparam logic [7:0] ADDR_ROW2   = 8'hC0;
  localparam logic [7:0] SET_4BIT    = 8'h28;
  localparam logic [7:0] SET_OFF     = 8'h08;
  localparam logic [7:0] SET_CLEAR   = 8'h01;
  localparam logic [7:0] SET_ENTRY   = 8'h06;
  localparam logic [7:0] SET_ON      = 8'h0C;
  localparam logic [3:0] WAKE_FIRST  = 4'h3;
  localparam logic [3:0] WAKE_SECOND = 4'h2;
  localparam logic [3:0] WAKE_THIRD  = 4'h0;

  // Pin levels the display currently sees.
  logic [3:0] pin_nibble;
  logic       pin_rs;
  logic       pin_en;

  // Segments of the request being expanded, and all segments still owed.
  pin_seg_t run_q[$];
  pin_seg_t owed_segs[$];

  function automatic void drive_pins(input logic rs, input logic en,
                                     input logic [3:0] nib, input logic [4:0] hold);
    pin_seg_t s;
    pin_rs     = rs;
    pin_en     = en;
    pin_nibble = nib;
    s = '{rs, en, nib, hold, 1'b0};
    run_q.push_back(s);
  endfunction

  // A command byte is latched by two strobes, high nibble first.
  function automatic void send_command(input logic [7:0] b);
    drive_pins(1'b0, 1'b0, pin_nibble, MS_PULSE);
    drive_pins(1'b0, 1'b1, b[7:4], MS_PULSE);
    drive_pins(1'b0, 1'b0, b[7:4], MS_CMD_HI);
    drive_pins(1'b0, 1'b1, b[3:0], MS_PULSE);
    drive_pins(1'b0, 1'b0, b[3:0], MS_CMD_LO);
  endfunction

  // A character byte has its own timing and a settle segment before the
  // second strobe.
  function automatic void send_char(input logic [7:0] b);
    drive_pins(1'b1, 1'b0, pin_nibble, MS_PULSE);
    drive_pins(1'b1, 1'b1, b[7:4], MS_PULSE);
    drive_pins(1'b1, 1'b0, b[7:4], MS_PULSE);
    drive_pins(1'b1, 1'b0, b[3:0], MS_PULSE);
    drive_pins(1'b1, 1'b1, b[3:0], MS_PULSE);
    drive_pins(1'b1, 1'b0, b[3:0], MS_PULSE);
  endfunction

  // Rows other than the first and second leave the cursor alone.
  function automatic void move_cursor(input logic [1:0] r, input logic [7:0] c);
    if (r == clns_pkg::ROW_FIRST) begin
      send_command(ADDR_ROW1 + c);
    end else if (r == clns_pkg::ROW_SECOND) begin
      send_command(ADDR_ROW2 + c);
    end
  endfunction

  function automatic void expand_request(input logic [2:0] t, input logic [7:0] b,
                                         input logic [1:0] r, input logic [7:0] c);
    pin_seg_t tail;
    run_q.delete();
    case (t)
      clns_pkg::REQ_CMD:  send_command(b);
      clns_pkg::REQ_CHAR: send_char(b);
      clns_pkg::REQ_GOTO: move_cursor(r, c);
      clns_pkg::REQ_CHAR_AT: begin
        move_cursor(r, c);
        send_char(b);
      end
      clns_pkg::REQ_INIT: begin
        drive_pins(pin_rs, pin_en, pin_nibble, MS_POWER);
        drive_pins(1'b0, pin_en, WAKE_FIRST, MS_WAKE);
        drive_pins(1'b0, pin_en, WAKE_SECOND, MS_WAKE);
        drive_pins(1'b0, pin_en, WAKE_THIRD, MS_NONE);
        send_command(SET_4BIT);
        send_command(SET_OFF);
        send_command(SET_CLEAR);
        send_command(SET_ENTRY);
        send_command(SET_ON);
      end
      default: ;
    endcase
    if (run_q.size() > 0) begin
      tail = run_q.pop_back();
      tail.last = 1'b1;
      run_q.push_back(tail);
    end
    foreach (run_q[i]) owed_segs.push_back(run_q[i]);
  endfunction

  function automatic string seg_text(input pin_seg_t s);
    return $sformatf("rs=%0b en=%0b nibble=%h hold=%0d last=%0b",
                     s.rs, s.en, s.nibble, s.hold_ms, s.last);
  endfunction

  // Sample both channels on the rising edge; new expectations go to the
  // back of the queue, so their order against the compare does not matter.
  always @(posedge clk_i or negedge rst_ni) begin
    pin_seg_t seen;
    pin_seg_t want;
    if (!rst_ni) begin
      pin_nibble   = '0;
      pin_rs       = 1'b0;
      pin_en       = 1'b0;
      owed_segs.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (req_mon.valid && req_mon.ready) begin
        expand_request(req_mon.req_type, req_mon.byte_value, req_mon.row,
                       req_mon.column);
      end
      if (seg_mon.valid && seg_mon.ready) begin
        seen = '{seg_mon.rs_level, seg_mon.en_level, seg_mon.data_nibble,
                 seg_mon.hold_ms, seg_mon.last};
        if (owed_segs.size() == 0) begin
          $display("%0t: segment with none expected: %s", $time, seg_text(seen));
          fail_count_o++;
        end else begin
          want = owed_segs.pop_front();
          if (seen !== want) begin
            $display("%0t: segment mismatch, expected %s, actual %s", $time,
                     seg_text(want), seg_text(seen));
            fail_count_o++;
          end
        end
      end
      pending_o = owed_segs.size();
    end
  end

endmodule

FILE: tb/tb.sv
// Stimulus and verdict for the LCD sequencer: a directed set of requests,
// then random ones sent in bursts while the segment receiver stalls.
module tb;

  // Request types the block has no use for.
  localparam logic [2:0] REQ_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNDEF_LAST  = 3'd7;
  localparam int         RANDOM_ITEMS    = 400;
  localparam int         TAIL_CYCLES     = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #4 clk_i = ~clk_i;

  clns_req_if req_if ();
  clns_seg_if seg_if ();

  // Values driven onto the channels, all known from time zero.
  logic       tx_valid  = 1'b0;
  logic [2:0] tx_type   = '0;
  logic [7:0] tx_byte   = '0;
  logic [1:0] tx_row    = '0;
  logic [7:0] tx_column = '0;
  logic       rx_ready  = 1'b0;

  assign req_if.valid      = tx_valid;
  assign req_if.req_type   = tx_type;
  assign req_if.byte_value = tx_byte;
  assign req_if.row        = tx_row;
  assign req_if.column     = tx_column;
  assign seg_if.ready      = rx_ready;

  int fail_count;
  int owed_count;
  int burst_left = 0;
  bit no_gaps    = 1'b0;
  int rx_mode    = 0;
  int rx_span    = 0;

  char_lcd_nibble_sequencer dut (
    .clk_i,
    .rst_ni,
    .req_i (req_if),
    .seg_o (seg_if)
  );

  lcd_segment_checker u_seg_check (
    .clk_i,
    .rst_ni,
    .req_mon      (req_if),
    .seg_mon      (seg_if),
    .fail_count_o (fail_count),
    .pending_o    (owed_count)
  );

  // Receiver: stretches of full speed, coin flips, long stalls and light
  // stalls, each of random length.
  always @(negedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_span = $urandom_range(20, 200);
    end
    rx_span--;
    case (rx_mode)
      0:       rx_ready <= 1'b1;
      1:       rx_ready <= ($urandom_range(0, 1) == 1);
      2:       rx_ready <= ($urandom_range(0, 7) == 0);
      default: rx_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Send one request; between bursts the valid line may drop for a random gap.
  task automatic send_req(input logic [2:0] t, input logic [7:0] b,
                          input logic [1:0] r, input logic [7:0] c);
    int gap;
    if (burst_left == 0) begin
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
        tx_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 10);
    end
    burst_left--;
    tx_valid  <= 1'b1;
    tx_type   <= t;
    tx_byte   <= b;
    tx_row    <= r;
    tx_column <= c;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Hold off the sender until every owed segment has been transferred.
  task automatic wait_drained();
    tx_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (owed_count != 0);
  endtask

  initial begin
    int   sent;
    int   pick;
    logic [2:0] t;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: init from reset, byte extremes, every goto row and the
    // column wrap, placed characters on bad rows, unknown types.
    send_req(clns_pkg::REQ_INIT, 8'h00, 2'd0, 8'h00);
    send_req(clns_pkg::REQ_CMD, 8'h00, 2'd3, 8'hFF);
    send_req(clns_pkg::REQ_CMD, 8'hFF, 2'd0, 8'h00);
    send_req(clns_pkg::REQ_CMD, 8'hA5, 2'd1, 8'h5A);
    send_req(clns_pkg::REQ_CHAR, 8'h00, 2'd2, 8'hFF);
    send_req(clns_pkg::REQ_CHAR, 8'hFF, 2'd1, 8'h00);
    send_req(clns_pkg::REQ_INIT, 8'hFF, 2'd3, 8'hFF);
    send_req(clns_pkg::REQ_GOTO, 8'hFF, clns_pkg::ROW_FIRST, 8'h00);
    send_req(clns_pkg::REQ_GOTO, 8'h00, clns_pkg::ROW_SECOND, 8'h3F);
    send_req(clns_pkg::REQ_GOTO, 8'h12, clns_pkg::ROW_FIRST, 8'hFF);
    send_req(clns_pkg::REQ_GOTO, 8'h34, clns_pkg::ROW_SECOND, 8'h40);
    send_req(clns_pkg::REQ_GOTO, 8'h56, 2'd0, 8'h12);
    send_req(clns_pkg::REQ_GOTO, 8'h78, 2'd3, 8'hFF);
    send_req(clns_pkg::REQ_CHAR_AT, 8'h41, clns_pkg::ROW_FIRST, 8'h05);
    send_req(clns_pkg::REQ_CHAR_AT, 8'h80, clns_pkg::ROW_SECOND, 8'hFF);
    send_req(clns_pkg::REQ_CHAR_AT, 8'h33, 2'd0, 8'h10);
    send_req(clns_pkg::REQ_CHAR_AT, 8'hFF, 2'd3, 8'h00);
    for (t = REQ_UNDEF_FIRST; t != 3'd0; t++) begin
      send_req(t, 8'hFF, 2'd3, 8'hFF);
    end
    send_req(clns_pkg::REQ_CMD, 8'h5A, 2'd2, 8'hAA);
    send_req(clns_pkg::REQ_INIT, 8'h55, 2'd1, 8'h55);
    wait_drained();

    // Random: a stretch without sender gaps in the middle, one full drain.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_gaps = (sent >= 100 && sent < 180);
      if (sent == 250) wait_drained();
      pick = $urandom_range(0, 99);
      if (pick < 22)      t = clns_pkg::REQ_CMD;
      else if (pick < 46) t = clns_pkg::REQ_CHAR;
      else if (pick < 62) t = clns_pkg::REQ_GOTO;
      else if (pick < 84) t = clns_pkg::REQ_CHAR_AT;
      else if (pick < 92) t = clns_pkg::REQ_INIT;
      else                t = 3'($urandom_range(REQ_UNDEF_FIRST, REQ_UNDEF_LAST));
      send_req(t, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
               8'($urandom_range(0, 255)));
      sent++;
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("char_lcd_nibble_sequencer test passed");
    end else begin
      $display("char_lcd_nibble_sequencer test failed");
    end
    $finish;
  end

  // Give up on a hung run.
  initial begin
    #5000000;
    $display("char_lcd_nibble_sequencer test failed");
    $finish;
  end

endmodule

FILE: char_lcd_nibble_sequencer.f
+incdir+hw/rtl
hw/rtl/clns_pkg.sv
hw/rtl/clns_req_if.sv
hw/rtl/clns_seg_if.sv
hw/rtl/clns_ctrl.sv
hw/rtl/clns_datapath.sv
hw/rtl/char_lcd_nibble_sequencer.sv
tb/lcd_segment_checker.sv
tb/tb.sv
